### src/tcbe_pkg.sv
// shared types, constants and codes for the touch calibrate button events block
// depends on nothing; used by touch_calibrate_button_events_top
`timescale 1ns / 1ps
`default_nettype none

package tcbe_pkg;

    localparam int RAW_BITS          = 16;
    localparam int SCREEN_COORD_BITS = 10;
    localparam int CAL_BITS          = 12;
    localparam int PRESS_BITS        = 12;
    localparam int CFG_DATA_BITS     = 12;
    localparam int CFG_ADDR_BITS     = 3;

    // product magnitude of (raw - min) * size, and one quotient bit per divider step
    localparam int PROD_W    = RAW_BITS - 1 + SCREEN_COORD_BITS;
    localparam int DIV_STEPS = PROD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [CAL_BITS-1:0]          X_RAW_MIN_RST   = CAL_BITS'(320);
    localparam logic [CAL_BITS-1:0]          X_RAW_MAX_RST   = CAL_BITS'(3945);
    localparam logic [CAL_BITS-1:0]          Y_RAW_MIN_RST   = CAL_BITS'(420);
    localparam logic [CAL_BITS-1:0]          Y_RAW_MAX_RST   = CAL_BITS'(3915);
    localparam logic [SCREEN_COORD_BITS-1:0] SCREEN_W_RST    = SCREEN_COORD_BITS'(320);
    localparam logic [SCREEN_COORD_BITS-1:0] SCREEN_H_RST    = SCREEN_COORD_BITS'(480);
    localparam logic                         PCHECK_RST      = 1'b1;
    localparam logic [PRESS_BITS-1:0]        PRESS_FLOOR_RST = PRESS_BITS'(400);

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_X_RAW_MIN     = 3'd0,
        CFG_X_RAW_MAX     = 3'd1,
        CFG_Y_RAW_MIN     = 3'd2,
        CFG_Y_RAW_MAX     = 3'd3,
        CFG_SCREEN_WIDTH  = 3'd4,
        CFG_SCREEN_HEIGHT = 3'd5,
        CFG_PCHECK_ON     = 3'd6,
        CFG_PRESS_FLOOR   = 3'd7
    } cfg_addr_t;

    typedef enum logic [2:0] {
        EVT_BUTTON_ONE   = 3'd0,
        EVT_BUTTON_TWO   = 3'd1,
        EVT_BUTTON_THREE = 3'd2,
        EVT_TOUCH_PRESS  = 3'd3,
        EVT_TOUCH_REL    = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        BTN_NONE  = 2'd0,
        BTN_ONE   = 2'd1,
        BTN_TWO   = 2'd2,
        BTN_THREE = 2'd3
    } button_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MUL  = 2'd1,
        ST_DIV  = 2'd2,
        ST_EMIT = 2'd3
    } state_t;

    typedef struct packed {
        logic                       button_one;
        logic                       button_two;
        logic                       button_three;
        logic                       touched;
        logic signed [RAW_BITS-1:0] raw_x;
        logic signed [RAW_BITS-1:0] raw_y;
        logic [PRESS_BITS-1:0]      raw_pressure;
    } poll_t;

    typedef struct packed {
        logic [2:0]                   event_code;
        logic [SCREEN_COORD_BITS-1:0] screen_x;
        logic [SCREEN_COORD_BITS-1:0] screen_y;
        logic [PRESS_BITS-1:0]        pressure_out;
        logic                         last;
    } event_beat_t;

endpackage

`default_nettype wire

### src/touch_calibrate_button_events_top.sv
// top level of the touch calibrate button events block: poll decode, shared divider
// depends on tcbe_pkg
`timescale 1ns / 1ps
`default_nettype none

// channel  | direction | handshake               | beat
// ---------+-----------+-------------------------+-----------------------------------
// poll     | in        | poll_valid / poll_ready | buttons, touched, raw x/y, pressure
// evt      | out       | evt_valid / evt_ready   | event code, screen x/y, pressure, last
// cfg      | in        | cfg_valid / cfg_ready   | register address, write data
//
// a poll without a valid touch sample is accepted in idle and goes to emit only for a new button or a touch release
// a touch press maps x then y in one shared restoring divider, each axis taking a multiply
// step and then one divider step per quotient bit, before the emit state sends the beats
// poll_ready is high only while the sequencer is idle; a held output beat stalls emit
// cfg_ready is always high; reset loads the calibration defaults and clears the
// active button and touch state

module touch_calibrate_button_events_top (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    poll_valid,
    output logic                                         poll_ready,
    input  wire tcbe_pkg::poll_t                         poll,
    output logic                                         evt_valid,
    input  wire logic                                    evt_ready,
    output tcbe_pkg::event_beat_t                        evt,
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [tcbe_pkg::CFG_ADDR_BITS-1:0]      cfg_addr,
    input  wire logic [tcbe_pkg::CFG_DATA_BITS-1:0]      cfg_wdata
);

    localparam int RB = tcbe_pkg::RAW_BITS;
    localparam int CB = tcbe_pkg::CAL_BITS;
    localparam int SB = tcbe_pkg::SCREEN_COORD_BITS;
    localparam int PB = tcbe_pkg::PRESS_BITS;
    localparam int PW = tcbe_pkg::PROD_W;
    localparam int SW = tcbe_pkg::STEP_W;

    // configuration registers
    logic [CB-1:0] x_raw_min_reg, x_raw_max_reg, y_raw_min_reg, y_raw_max_reg;
    logic [SB-1:0] screen_width_reg, screen_height_reg;
    logic          pcheck_on_reg;
    logic [PB-1:0] press_floor_reg;

    // sequencer and poll state
    tcbe_pkg::state_t   state_reg, state_next;
    tcbe_pkg::button_t  active_btn_reg, active_btn_next;
    logic               touch_active_reg, touch_active_next;
    logic               btn_pend_reg, btn_pend_next;
    tcbe_pkg::event_t   btn_code_reg, btn_code_next;
    logic               touch_pend_reg, touch_pend_next;
    logic               touch_press_reg, touch_press_next;
    logic               axis_reg, axis_next;          // 0 x, 1 y

    // sample and divider datapath
    logic [RB-2:0]      raw_x_reg, raw_x_next, raw_y_reg, raw_y_next;
    logic [PB-1:0]      press_reg, press_next;
    logic [PW-1:0]      work_reg, work_next;          // dividend in, quotient out
    logic [CB:0]        rem_reg, rem_next;
    logic [CB-1:0]      divisor_reg, divisor_next;
    logic               kill_reg, kill_next;          // zero span or negative quotient
    logic [SW-1:0]      step_reg, step_next;
    logic [SB-1:0]      sx_reg, sx_next, my_reg, my_next;

    // output stage
    logic                  evt_valid_reg, evt_valid_next;
    tcbe_pkg::event_beat_t evt_reg, evt_next;

    // accept decode
    logic               poll_fire;
    tcbe_pkg::button_t  btn_sel;
    logic               btn_event;
    logic               sample_ok;
    logic               touch_release;
    logic               touch_press;
    logic               load_ok;

    // per-axis mapping operands
    logic [RB-2:0]      raw_sel;
    logic [CB-1:0]      lo_sel, hi_sel;
    logic [SB-1:0]      top_sel;
    logic [RB:0]        num;
    logic [RB:0]        num_mag_full;
    logic [RB-2:0]      num_mag;
    logic [CB:0]        span;
    logic [CB:0]        span_mag_full;
    logic [PW-1:0]      product;

    // one divider step
    logic [CB:0]        rem_shift;
    logic               fits;
    logic [SB-1:0]      mapped;
    logic               last_step;

    assign poll_ready = (state_reg == tcbe_pkg::ST_IDLE);
    assign poll_fire  = poll_valid && poll_ready;
    assign cfg_ready  = 1'b1;
    assign evt_valid  = evt_valid_reg;
    assign evt        = evt_reg;
    assign load_ok    = !evt_valid_reg || evt_ready;

    // button priority 1 over 2 over 3
    always_comb
    begin
        if (poll.button_one)
            btn_sel = tcbe_pkg::BTN_ONE;
        else if (poll.button_two)
            btn_sel = tcbe_pkg::BTN_TWO;
        else if (poll.button_three)
            btn_sel = tcbe_pkg::BTN_THREE;
        else
            btn_sel = tcbe_pkg::BTN_NONE;
    end

    assign btn_event     = (btn_sel != tcbe_pkg::BTN_NONE) && (btn_sel != active_btn_reg);
    assign sample_ok     = !(pcheck_on_reg && (poll.raw_pressure < press_floor_reg))
                           && !poll.raw_x[RB-1] && !poll.raw_y[RB-1];
    assign touch_release = !poll.touched && touch_active_reg;
    assign touch_press   = poll.touched && sample_ok;

    // operand select for the axis being mapped
    assign raw_sel = axis_reg ? raw_y_reg : raw_x_reg;
    assign lo_sel  = axis_reg ? y_raw_min_reg : x_raw_min_reg;
    assign hi_sel  = axis_reg ? y_raw_max_reg : x_raw_max_reg;
    assign top_sel = axis_reg ? screen_height_reg : screen_width_reg;

    assign num          = {2'b00, raw_sel} - {{(RB + 1 - CB){1'b0}}, lo_sel};
    assign num_mag_full = num[RB] ? (~num + 1'b1) : num;
    assign num_mag      = num_mag_full[RB-2:0];
    assign span         = {1'b0, hi_sel} - {1'b0, lo_sel};
    assign span_mag_full = span[CB] ? (~span + 1'b1) : span;
    assign product      = PW'(num_mag) * PW'(top_sel);

    // restoring divide, one quotient bit a cycle
    assign rem_shift = {rem_reg[CB-1:0], work_reg[PW-1]};
    assign fits      = rem_shift >= {1'b0, divisor_reg};
    assign last_step = (step_reg == SW'(tcbe_pkg::DIV_STEPS - 1));

    // clamp the finished quotient against the axis size, or force zero on a killed divide
    always_comb
    begin
        if (kill_reg)
            mapped = '0;
        else if (work_next > PW'(top_sel))
            mapped = top_sel;
        else
            mapped = work_next[SB-1:0];
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcbe_pkg::ST_IDLE:
            begin
                if (poll_fire)
                begin
                    if (touch_press)
                        state_next = tcbe_pkg::ST_MUL;
                    else if (btn_event || touch_release)
                        state_next = tcbe_pkg::ST_EMIT;
                end
            end
            tcbe_pkg::ST_MUL:
                state_next = tcbe_pkg::ST_DIV;
            tcbe_pkg::ST_DIV:
            begin
                if (last_step)
                    state_next = axis_reg ? tcbe_pkg::ST_EMIT : tcbe_pkg::ST_MUL;
            end
            tcbe_pkg::ST_EMIT:
            begin
                if (load_ok && !(btn_pend_reg && touch_pend_reg))
                    state_next = tcbe_pkg::ST_IDLE;
            end
            default:
                state_next = tcbe_pkg::ST_IDLE;
        endcase
    end

    // datapath and output next values
    always_comb
    begin
        active_btn_next   = active_btn_reg;
        touch_active_next = touch_active_reg;
        btn_pend_next     = btn_pend_reg;
        btn_code_next     = btn_code_reg;
        touch_pend_next   = touch_pend_reg;
        touch_press_next  = touch_press_reg;
        axis_next         = axis_reg;
        raw_x_next        = raw_x_reg;
        raw_y_next        = raw_y_reg;
        press_next        = press_reg;
        work_next         = work_reg;
        rem_next          = rem_reg;
        divisor_next      = divisor_reg;
        kill_next         = kill_reg;
        step_next         = step_reg;
        sx_next           = sx_reg;
        my_next           = my_reg;
        evt_valid_next    = evt_valid_reg && !evt_ready;
        evt_next          = evt_reg;

        if (fits)
        begin
            rem_next  = rem_shift - {1'b0, divisor_reg};
            work_next = {work_reg[PW-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_shift;
            work_next = {work_reg[PW-2:0], 1'b0};
        end

        unique case (state_reg)
            tcbe_pkg::ST_IDLE:
            begin
                work_next = work_reg;
                rem_next  = rem_reg;
                if (poll_fire)
                begin
                    raw_x_next    = poll.raw_x[RB-2:0];
                    raw_y_next    = poll.raw_y[RB-2:0];
                    press_next    = poll.raw_pressure;
                    axis_next     = 1'b0;
                    btn_pend_next = btn_event;
                    unique case (btn_sel)
                        tcbe_pkg::BTN_TWO:   btn_code_next = tcbe_pkg::EVT_BUTTON_TWO;
                        tcbe_pkg::BTN_THREE: btn_code_next = tcbe_pkg::EVT_BUTTON_THREE;
                        default:             btn_code_next = tcbe_pkg::EVT_BUTTON_ONE;
                    endcase
                    if (btn_sel == tcbe_pkg::BTN_NONE)
                        active_btn_next = tcbe_pkg::BTN_NONE;
                    else if (btn_event)
                        active_btn_next = btn_sel;
                    touch_pend_next  = touch_release || touch_press;
                    touch_press_next = touch_press;
                    if (touch_release)
                        touch_active_next = 1'b0;
                    else if (touch_press)
                        touch_active_next = 1'b1;
                end
            end
            tcbe_pkg::ST_MUL:
            begin
                work_next    = product;
                rem_next     = '0;
                divisor_next = span_mag_full[CB-1:0];
                kill_next    = (span == '0) || (num[RB] != span[CB]);
                step_next    = '0;
            end
            tcbe_pkg::ST_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (last_step)
                begin
                    if (axis_reg)
                        my_next = mapped;
                    else
                        sx_next = mapped;
                    axis_next = 1'b1;
                end
            end
            tcbe_pkg::ST_EMIT:
            begin
                work_next = work_reg;
                rem_next  = rem_reg;
                if (load_ok)
                begin
                    evt_valid_next = 1'b1;
                    if (btn_pend_reg)
                    begin
                        btn_pend_next = 1'b0;
                        evt_next      = '{event_code:   btn_code_reg,
                                          screen_x:     '0,
                                          screen_y:     '0,
                                          pressure_out: '0,
                                          last:         !touch_pend_reg};
                    end
                    else if (touch_press_reg)
                    begin
                        touch_pend_next = 1'b0;
                        evt_next        = '{event_code:   tcbe_pkg::EVT_TOUCH_PRESS,
                                            screen_x:     sx_reg,
                                            screen_y:     screen_height_reg - my_reg,
                                            pressure_out: press_reg,
                                            last:         1'b1};
                    end
                    else
                    begin
                        touch_pend_next = 1'b0;
                        evt_next        = '{event_code:   tcbe_pkg::EVT_TOUCH_REL,
                                            screen_x:     '0,
                                            screen_y:     '0,
                                            pressure_out: '0,
                                            last:         1'b1};
                    end
                end
            end
            default:
            begin
                work_next = work_reg;
                rem_next  = rem_reg;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_raw_min_reg     <= tcbe_pkg::X_RAW_MIN_RST;
            x_raw_max_reg     <= tcbe_pkg::X_RAW_MAX_RST;
            y_raw_min_reg     <= tcbe_pkg::Y_RAW_MIN_RST;
            y_raw_max_reg     <= tcbe_pkg::Y_RAW_MAX_RST;
            screen_width_reg  <= tcbe_pkg::SCREEN_W_RST;
            screen_height_reg <= tcbe_pkg::SCREEN_H_RST;
            pcheck_on_reg     <= tcbe_pkg::PCHECK_RST;
            press_floor_reg   <= tcbe_pkg::PRESS_FLOOR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (tcbe_pkg::cfg_addr_t'(cfg_addr))
                tcbe_pkg::CFG_X_RAW_MIN:     x_raw_min_reg     <= cfg_wdata[CB-1:0];
                tcbe_pkg::CFG_X_RAW_MAX:     x_raw_max_reg     <= cfg_wdata[CB-1:0];
                tcbe_pkg::CFG_Y_RAW_MIN:     y_raw_min_reg     <= cfg_wdata[CB-1:0];
                tcbe_pkg::CFG_Y_RAW_MAX:     y_raw_max_reg     <= cfg_wdata[CB-1:0];
                tcbe_pkg::CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_wdata[SB-1:0];
                tcbe_pkg::CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_wdata[SB-1:0];
                tcbe_pkg::CFG_PCHECK_ON:     pcheck_on_reg     <= cfg_wdata[0];
                tcbe_pkg::CFG_PRESS_FLOOR:   press_floor_reg   <= cfg_wdata[PB-1:0];
                default:                     press_floor_reg   <= press_floor_reg;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tcbe_pkg::ST_IDLE;
            active_btn_reg   <= tcbe_pkg::BTN_NONE;
            touch_active_reg <= 1'b0;
            btn_pend_reg     <= 1'b0;
            touch_pend_reg   <= 1'b0;
            evt_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            active_btn_reg   <= active_btn_next;
            touch_active_reg <= touch_active_next;
            btn_pend_reg     <= btn_pend_next;
            touch_pend_reg   <= touch_pend_next;
            evt_valid_reg    <= evt_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        btn_code_reg    <= btn_code_next;
        touch_press_reg <= touch_press_next;
        axis_reg        <= axis_next;
        raw_x_reg       <= raw_x_next;
        raw_y_reg       <= raw_y_next;
        press_reg       <= press_next;
        work_reg        <= work_next;
        rem_reg         <= rem_next;
        divisor_reg     <= divisor_next;
        kill_reg        <= kill_next;
        step_reg        <= step_next;
        sx_reg          <= sx_next;
        my_reg          <= my_next;
        evt_reg         <= evt_next;
    end

    // a live divide never runs against a zero divisor
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcbe_pkg::ST_DIV) && !kill_reg |-> (divisor_reg != '0))
        else $error("divider running with zero divisor");

    // emit is only entered with something left to send
    a_emit_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcbe_pkg::ST_EMIT) |-> (btn_pend_reg || touch_pend_reg))
        else $error("emit state with nothing pending");

    // mapped x and y stay inside the screen once both axes are done
    a_x_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcbe_pkg::ST_EMIT) && touch_press_reg |-> (sx_reg <= screen_width_reg)
        && (my_reg <= screen_height_reg))
        else $error("mapped coordinate beyond screen size");

    // only press beats carry coordinates and pressure
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid_reg && (evt_reg.event_code != tcbe_pkg::EVT_TOUCH_PRESS)
        |-> (evt_reg.screen_x == '0) && (evt_reg.screen_y == '0)
            && (evt_reg.pressure_out == '0))
        else $error("non-press beat with nonzero payload");

endmodule

`default_nettype wire
